### rtl/gbfp_pkg.sv
// ----------------------------------------------------------------------------
// gbfp_pkg: shared types and constants of the binary frame parser
// Parse phases, event codes, framing bytes and the state and result records.
// ----------------------------------------------------------------------------
`default_nettype none

package gbfp_pkg;

    // framing bytes
    localparam logic [7:0] SYNC_ONE  = 8'hB5;
    localparam logic [7:0] SYNC_TWO  = 8'h62;
    localparam logic [7:0] NAV_CLASS = 8'h01;

    // event codes
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_PAYLOAD = 3'd1;
    localparam logic [2:0] EV_GOOD    = 3'd2;
    localparam logic [2:0] EV_BAD     = 3'd3;
    localparam logic [2:0] EV_DROP    = 3'd4;

    // largest length shown on the result word
    localparam logic [9:0] LEN_SHOWN_MAX = 10'h3FF;

    typedef enum logic [3:0] {
        PH_SYNC1  = 4'd0,
        PH_SYNC2  = 4'd1,
        PH_CLASS  = 4'd2,
        PH_ID     = 4'd3,
        PH_LEN_LO = 4'd4,
        PH_LEN_HI = 4'd5,
        PH_DATA   = 4'd6,
        PH_CK_A   = 4'd7,
        PH_CK_B   = 4'd8
    } gbfp_phase_t;

    // parser state that does not depend on the payload limit
    typedef struct packed {
        gbfp_phase_t phase;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [15:0] length;
        logic [7:0]  sum_a;
        logic [7:0]  sum_b;
        logic [7:0]  received_a;
        logic [31:0] time_capture;
        logic [31:0] last_nav_time;
    } gbfp_state_t;

    // one result word
    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  payload_byte;
        logic [8:0]  payload_index;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [9:0]  payload_length;
        logic [31:0] nav_time;
    } gbfp_result_t;

endpackage

`default_nettype wire

### rtl/gbfp_step.sv
// ----------------------------------------------------------------------------
// gbfp_step: per-byte update of the frame parser
// Combinational next state and result word for one received byte.
// ----------------------------------------------------------------------------
`default_nettype none

module gbfp_step #(
    parameter int MAX_PAYLOAD = 512,
    parameter int IDX_W       = 10
) (
    input  var gbfp_pkg::gbfp_state_t  cur,
    input  wire logic [IDX_W-1:0]      cur_idx,
    input  wire logic [7:0]            rx_byte,
    output var gbfp_pkg::gbfp_state_t  nxt,
    output logic      [IDX_W-1:0]      nxt_idx,
    output var gbfp_pkg::gbfp_result_t res
);
    import gbfp_pkg::*;

    logic [7:0]   a_add;
    logic [7:0]   b_add;
    logic [15:0]  len_new;
    logic [IDX_W:0] idx_inc;

    // running fletcher sums with this byte
    assign a_add   = cur.sum_a + rx_byte;
    assign b_add   = cur.sum_b + a_add;
    assign len_new = {rx_byte, cur.length[7:0]};
    assign idx_inc = {1'b0, cur_idx} + {{IDX_W{1'b0}}, 1'b1};

    // phase decoder
    always_comb begin
        nxt               = cur;
        nxt_idx           = cur_idx;
        res.event_res     = EV_NONE;
        res.payload_byte  = 8'd0;
        res.payload_index = 9'd0;
        unique case (cur.phase)
            PH_SYNC1: begin
                nxt.sum_a = 8'd0;
                nxt.sum_b = 8'd0;
                if (rx_byte == SYNC_ONE) begin
                    nxt.phase = PH_SYNC2;
                end
            end
            PH_SYNC2: begin
                nxt.phase = (rx_byte == SYNC_TWO) ? PH_CLASS : PH_SYNC1;
            end
            PH_CLASS: begin
                nxt.msg_class = rx_byte;
                nxt.sum_a     = a_add;
                nxt.sum_b     = b_add;
                nxt.phase     = PH_ID;
            end
            PH_ID: begin
                nxt.msg_id = rx_byte;
                nxt.sum_a  = a_add;
                nxt.sum_b  = b_add;
                nxt.phase  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                nxt.length = {8'd0, rx_byte};
                nxt.sum_a  = a_add;
                nxt.sum_b  = b_add;
                nxt.phase  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                nxt.length = len_new;
                nxt.sum_a  = a_add;
                nxt.sum_b  = b_add;
                nxt_idx    = '0;
                if ({16'd0, len_new} > 32'(MAX_PAYLOAD)) begin
                    res.event_res = EV_DROP;
                    nxt.phase     = PH_SYNC1;
                end else if (len_new == 16'd0) begin
                    nxt.phase = PH_CK_A;
                end else begin
                    nxt.phase = PH_DATA;
                end
            end
            PH_DATA: begin
                res.event_res     = EV_PAYLOAD;
                res.payload_byte  = rx_byte;
                res.payload_index = 9'(cur_idx);
                // first four payload bytes form the time word
                if (32'(cur_idx) < 32'd4) begin
                    case (cur_idx[1:0])
                        2'd0:    nxt.time_capture[7:0]   = rx_byte;
                        2'd1:    nxt.time_capture[15:8]  = rx_byte;
                        2'd2:    nxt.time_capture[23:16] = rx_byte;
                        default: nxt.time_capture[31:24] = rx_byte;
                    endcase
                end
                nxt.sum_a = a_add;
                nxt.sum_b = b_add;
                nxt_idx   = idx_inc[IDX_W-1:0];
                if (17'(idx_inc) >= {1'b0, cur.length}) begin
                    nxt.phase = PH_CK_A;
                end
            end
            PH_CK_A: begin
                nxt.received_a = rx_byte;
                nxt.phase      = PH_CK_B;
            end
            PH_CK_B: begin
                if (cur.received_a == cur.sum_a && rx_byte == cur.sum_b) begin
                    res.event_res = EV_GOOD;
                    if (cur.msg_class == NAV_CLASS) begin
                        nxt.last_nav_time = cur.time_capture;
                    end
                end else begin
                    res.event_res = EV_BAD;
                end
                nxt.phase = PH_SYNC1;
            end
            default: begin
                nxt.phase = PH_SYNC1;
            end
        endcase
        res.msg_class      = nxt.msg_class;
        res.msg_id         = nxt.msg_id;
        res.payload_length = (nxt.length > 16'(LEN_SHOWN_MAX)) ? LEN_SHOWN_MAX
                                                               : nxt.length[9:0];
        res.nav_time       = nxt.last_nav_time;
    end

endmodule

`default_nettype wire

### rtl/gnss_binary_frame_parser_core.sv
// ----------------------------------------------------------------------------
// gnss_binary_frame_parser_core: byte-serial binary frame parser
// Finds sync pairs, reads the header, streams payload bytes with their index,
// checks the fletcher-8 sum and keeps the time word of good nav frames.
//
//   channel  direction  handshake           fields
//   s_       in         s_valid / s_ready   s_rx_byte
//   m_       out        m_valid / m_ready   m_event_res .. m_nav_time
//
// one word in, one result word out; a word is accepted every cycle unless a held result waits on m_ready
// the result is registered and appears in the cycle after its word is accepted
// the parser state, the payload index and the result register are the only storage
// s_ready is low only while a result is held and m_ready is low
// synchronous active-low reset returns the parser to sync hunting
// ----------------------------------------------------------------------------
`default_nettype none

module gnss_binary_frame_parser_core #(
    parameter int MAX_PAYLOAD = 512
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_event_res,
    output logic [7:0]       m_payload_byte,
    output logic [8:0]       m_payload_index,
    output logic [7:0]       m_msg_class,
    output logic [7:0]       m_msg_id,
    output logic [9:0]       m_payload_length,
    output logic [31:0]      m_nav_time
);
    import gbfp_pkg::*;

    localparam int IDX_W = $clog2(MAX_PAYLOAD + 1);

    gbfp_state_t      state_reg;
    gbfp_state_t      state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    gbfp_result_t     res_next;
    gbfp_result_t     res_reg;
    logic             valid_reg;
    logic             accept;

    assign s_ready = !valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    gbfp_step #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .IDX_W       (IDX_W)
    ) u_step (
        .cur     (state_reg),
        .cur_idx (idx_reg),
        .rx_byte (s_rx_byte),
        .nxt     (state_next),
        .nxt_idx (idx_next),
        .res     (res_next)
    );

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{phase: PH_SYNC1, default: '0};
            idx_reg   <= '0;
        end else if (accept) begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            res_reg   <= '0;
        end else begin
            if (accept) begin
                valid_reg <= 1'b1;
                res_reg   <= res_next;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid          = valid_reg;
    assign m_event_res      = res_reg.event_res;
    assign m_payload_byte   = res_reg.payload_byte;
    assign m_payload_index  = res_reg.payload_index;
    assign m_msg_class      = res_reg.msg_class;
    assign m_msg_id         = res_reg.msg_id;
    assign m_payload_length = res_reg.payload_length;
    assign m_nav_time       = res_reg.nav_time;

    // payload index stays inside the declared length
    a_idx_in_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res == EV_PAYLOAD |-> {1'b0, m_payload_index} < m_payload_length)
        else $error("payload index beyond declared length");

    // a drop only follows an over-limit length
    a_drop_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res == EV_DROP |->
            {22'd0, m_payload_length} > MAX_PAYLOAD || m_payload_length == LEN_SHOWN_MAX)
        else $error("drop without an over-limit length");

    // nav time moves only with a good frame
    a_nav_on_good: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(m_nav_time) |-> m_valid && m_event_res == EV_GOOD)
        else $error("nav time changed without a good frame");

    // event codes stay in range
    a_event_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_event_res <= EV_DROP)
        else $error("event code out of range");

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for gnss_binary_frame_parser_core
// Feeds received bytes through the s_ channel with random gaps and stalls
// the m_ channel at random. A byte-level model of the frame parser predicts
// one result word per accepted byte, and each result is checked field by
// field. Stimulus is a short directed set of frames, then mostly well-formed
// frames with random content, mixed with noise, dropped lengths, broken sync
// pairs and cut-off frames.
// ----------------------------------------------------------------------------
module testbench;

    import gbfp_pkg::*;

    localparam int PAYLOAD_LIMIT = 512;
    localparam int RANDOM_BYTES  = 1340;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int PRINT_LIMIT   = 40;

    logic        aclk             = 1'b0;
    logic        aresetn          = 1'b0;
    logic        s_valid          = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte        = 8'h00;
    logic        m_valid;
    logic        m_ready          = 1'b0;
    logic [2:0]  m_event_res;
    logic [7:0]  m_payload_byte;
    logic [8:0]  m_payload_index;
    logic [7:0]  m_msg_class;
    logic [7:0]  m_msg_id;
    logic [9:0]  m_payload_length;
    logic [31:0] m_nav_time;

    // byte stream still to send and result words still due
    logic [7:0]   tx_bytes[$];
    logic [7:0]   frame_body[$];
    gbfp_result_t expected_words[$];

    int tx_gap      = 0;
    int tx_quiet    = 0;
    int rx_stall    = 0;
    int rx_quiet    = 0;
    int words_total = 0;
    int words_taken = 0;
    int fail_count  = 0;
    int cycle_count = 0;

    // parser model state
    gbfp_phase_t parse_ph    = PH_SYNC1;
    logic [7:0]  frame_class = '0;
    logic [7:0]  frame_id    = '0;
    logic [15:0] frame_len   = '0;
    logic [15:0] data_count  = '0;
    logic [7:0]  run_a       = '0;
    logic [7:0]  run_b       = '0;
    logic [7:0]  held_a      = '0;
    logic [31:0] time_word   = '0;
    logic [31:0] nav_word    = '0;

    gnss_binary_frame_parser_core #(
        .MAX_PAYLOAD(PAYLOAD_LIMIT)
    ) uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_res     (m_event_res),
        .m_payload_byte  (m_payload_byte),
        .m_payload_index (m_payload_index),
        .m_msg_class     (m_msg_class),
        .m_msg_id        (m_msg_id),
        .m_payload_length(m_payload_length),
        .m_nav_time      (m_nav_time)
    );

    always #1 aclk = ~aclk;

    // run guard
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // mostly short gaps, a few long ones, and now and then a run with none
    function automatic int draw_gap(inout int quiet);
        int r;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            quiet = $urandom_range(40, 160);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task automatic fletcher_add(input logic [7:0] v);
        run_a += v;
        run_b += run_a;
    endtask

    // advance the parser model by one byte and queue the word it produces
    task automatic parse_rx_byte(input logic [7:0] rx);
        gbfp_result_t w;
        w = '0;
        case (parse_ph)
            PH_SYNC1: begin
                run_a = '0;
                run_b = '0;
                if (rx == SYNC_ONE) parse_ph = PH_SYNC2;
            end
            // a wrong second byte is never reused as a first sync byte
            PH_SYNC2: parse_ph = (rx == SYNC_TWO) ? PH_CLASS : PH_SYNC1;
            PH_CLASS: begin
                frame_class = rx;
                fletcher_add(rx);
                parse_ph = PH_ID;
            end
            PH_ID: begin
                frame_id = rx;
                fletcher_add(rx);
                parse_ph = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                frame_len = {8'h00, rx};
                fletcher_add(rx);
                parse_ph = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                frame_len[15:8] = rx;
                fletcher_add(rx);
                data_count = '0;
                if (frame_len > PAYLOAD_LIMIT) begin
                    w.event_res = EV_DROP;
                    parse_ph = PH_SYNC1;
                end else if (frame_len == 16'd0) begin
                    parse_ph = PH_CK_A;
                end else begin
                    parse_ph = PH_DATA;
                end
            end
            PH_DATA: begin
                w.event_res     = EV_PAYLOAD;
                w.payload_byte  = rx;
                w.payload_index = data_count[8:0];
                // first four payload bytes form the time word, little-endian
                if (data_count < 16'd4) time_word[data_count[1:0]*8 +: 8] = rx;
                fletcher_add(rx);
                data_count++;
                if (data_count >= frame_len) parse_ph = PH_CK_A;
            end
            PH_CK_A: begin
                held_a = rx;
                parse_ph = PH_CK_B;
            end
            PH_CK_B: begin
                if (held_a == run_a && rx == run_b) begin
                    w.event_res = EV_GOOD;
                    if (frame_class == NAV_CLASS) nav_word = time_word;
                end else begin
                    w.event_res = EV_BAD;
                end
                parse_ph = PH_SYNC1;
            end
            default: parse_ph = PH_SYNC1;
        endcase
        w.msg_class      = frame_class;
        w.msg_id         = frame_id;
        w.payload_length = (frame_len > 16'd1023) ? LEN_SHOWN_MAX : frame_len[9:0];
        w.nav_time       = nav_word;
        expected_words.push_back(w);
    endtask

    task automatic push_header(input logic [7:0] cls, input logic [7:0] id,
                               input logic [15:0] len);
        tx_bytes.push_back(SYNC_ONE);
        tx_bytes.push_back(SYNC_TWO);
        tx_bytes.push_back(cls);
        tx_bytes.push_back(id);
        tx_bytes.push_back(len[7:0]);
        tx_bytes.push_back(len[15:8]);
    endtask

    // whole frame around frame_body, optionally with one checksum bit flipped
    task automatic push_frame(input logic [7:0] cls, input logic [7:0] id,
                              input bit corrupt);
        logic [15:0] len;
        logic [7:0]  fa;
        logic [7:0]  fb;
        logic [7:0]  covered[$];
        int          k;
        len = 16'(frame_body.size());
        covered = {cls, id, len[7:0], len[15:8]};
        foreach (frame_body[i]) covered.push_back(frame_body[i]);
        fa = '0;
        fb = '0;
        foreach (covered[i]) begin
            fa += covered[i];
            fb += fa;
        end
        if (corrupt) begin
            k = $urandom_range(0, 7);
            if ($urandom_range(0, 1)) fa[k] = ~fa[k];
            else fb[k] = ~fb[k];
        end
        push_header(cls, id, len);
        foreach (frame_body[i]) tx_bytes.push_back(frame_body[i]);
        tx_bytes.push_back(fa);
        tx_bytes.push_back(fb);
    endtask

    task automatic fill_body(input int len);
        frame_body.delete();
        repeat (len) frame_body.push_back(8'($urandom));
    endtask

    task automatic build_directed();
        // second sync byte wrong, and itself a first sync byte
        tx_bytes.push_back(SYNC_ONE);
        tx_bytes.push_back(SYNC_ONE);
        tx_bytes.push_back(SYNC_TWO);
        // good nav frame with a full time word
        frame_body = {8'hFF, 8'h00, 8'h5A, 8'hA5};
        push_frame(NAV_CLASS, 8'hFF, 1'b0);
        // zero-length frame straight to a bad checksum
        frame_body.delete();
        push_frame(8'hFF, 8'h00, 1'b1);
        // largest declared length, dropped and shown saturated
        push_header(NAV_CLASS, NAV_CLASS, 16'hFFFF);
    endtask

    task automatic build_random();
        int          r;
        int          len;
        logic [7:0]  cls;
        logic [15:0] bad_len;
        while (tx_bytes.size() < RANDOM_BYTES) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                // well-formed frame, mostly short, now and then long
                r = $urandom_range(0, 99);
                if (r < 85) len = $urandom_range(0, 8);
                else if (r < 98) len = $urandom_range(9, 64);
                else len = $urandom_range(65, PAYLOAD_LIMIT);
                cls = ($urandom_range(0, 99) < 40) ? NAV_CLASS : 8'($urandom);
                fill_body(len);
                push_frame(cls, 8'($urandom), $urandom_range(0, 99) < 15);
            end else if (r < 78) begin
                case ($urandom_range(0, 3))
                    0: bad_len = 16'(PAYLOAD_LIMIT + 1);
                    1: bad_len = 16'hFFFF;
                    2: bad_len = 16'($urandom_range(1023, 1024));
                    default: bad_len = 16'($urandom_range(PAYLOAD_LIMIT + 1, 65535));
                endcase
                push_header(8'($urandom), 8'($urandom), bad_len);
            end else if (r < 88) begin
                repeat ($urandom_range(1, 6)) tx_bytes.push_back(8'($urandom));
            end else if (r < 94) begin
                // sync byte followed by a random second byte
                tx_bytes.push_back(SYNC_ONE);
                tx_bytes.push_back(8'($urandom));
            end else begin
                // frame cut short; what follows is parsed as its tail
                fill_body($urandom_range(0, 6));
                push_frame(NAV_CLASS, 8'($urandom), 1'b0);
                repeat ($urandom_range(1, 4)) void'(tx_bytes.pop_back());
            end
        end
        // one frame at the payload limit and one just over it
        fill_body(PAYLOAD_LIMIT);
        push_frame(NAV_CLASS, 8'($urandom), 1'b0);
        push_header(8'($urandom), 8'($urandom), 16'(PAYLOAD_LIMIT + 1));
    endtask

    // driver: one byte per word, random gaps between words
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                parse_rx_byte(s_rx_byte);
                words_taken++;
            end
            if (!s_valid || s_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (tx_bytes.size() > 0) begin
                    s_rx_byte <= tx_bytes.pop_front();
                    s_valid <= 1'b1;
                    tx_gap = draw_gap(tx_quiet);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result word against the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("result word with no prediction pending");
                end else begin
                    gbfp_result_t want;
                    want = expected_words.pop_front();
                    check_field("event_res", 32'(m_event_res), 32'(want.event_res));
                    check_field("payload_byte", 32'(m_payload_byte),
                                32'(want.payload_byte));
                    check_field("payload_index", 32'(m_payload_index),
                                32'(want.payload_index));
                    check_field("msg_class", 32'(m_msg_class), 32'(want.msg_class));
                    check_field("msg_id", 32'(m_msg_id), 32'(want.msg_id));
                    check_field("payload_length", 32'(m_payload_length),
                                32'(want.payload_length));
                    check_field("nav_time", m_nav_time, want.nav_time);
                end
                rx_stall = draw_gap(rx_quiet);
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // stimulus setup, reset and end of run
    initial begin
        build_directed();
        build_random();
        words_total = tx_bytes.size();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        do @(negedge aclk);
        while (words_taken < words_total || expected_words.size() > 0);
        // catch any stray late result
        repeat (16) @(negedge aclk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### sim.f
rtl/gbfp_pkg.sv
rtl/gbfp_step.sv
rtl/gnss_binary_frame_parser_core.sv
tb/sv/testbench.sv
